// ----- rtl/cab_pkg.sv -----
// ============================================================================
// cab_pkg: shared types and constants of the clipped alpha-blend blitter
// Holds the register indexes, the effective configuration bundle and the
// record that passes from the front end through the queue to the back end.
// ============================================================================
package cab_pkg;

    // Largest image or screen dimension the block handles.
    localparam int unsigned MaxDim     = 4096;
    localparam int unsigned DimW       = $clog2(MaxDim) + 1;  // holds MaxDim itself
    localparam int unsigned PosW       = DimW - 1;            // counter and coordinate width
    localparam int unsigned CfgW       = 13;
    localparam int unsigned IdxW       = 24;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QPtrW      = $clog2(QueueDepth);
    localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_IMAGE_WIDTH   = 3'd2,
        REG_IMAGE_HEIGHT  = 3'd3,
        REG_POS_X         = 3'd4,
        REG_POS_Y         = 3'd5
    } cab_reg_t;

    // Effective (clamped) configuration seen by the datapath.
    typedef struct packed {
        logic [DimW-1:0]        screen_width;
        logic [DimW-1:0]        screen_height;
        logic [DimW-1:0]        image_width;
        logic [DimW-1:0]        image_height;
        logic signed [CfgW-1:0] pos_x;
        logic signed [CfgW-1:0] pos_y;
    } cab_cfg_t;

    // One classified pixel on its way to the blend unit.
    typedef struct packed {
        logic            visible;
        logic            last;
        logic [PosW-1:0] x;
        logic [PosW-1:0] y;
        logic [31:0]     src;   // red, green, blue, alpha from the lowest byte up
        logic [31:0]     dst;   // red, green, blue, alpha from the lowest byte up
    } cab_item_t;

    // Image dimension: zero acts as one, anything above the limit as the limit.
    function automatic logic [DimW-1:0] image_dim(input logic [CfgW-1:0] v);
        logic [DimW-1:0] r;
        if (v == '0)
            r = DimW'(1);
        else if (v > CfgW'(MaxDim))
            r = DimW'(MaxDim);
        else
            r = DimW'(v);
        return r;
    endfunction

    // Screen dimension: anything above the limit acts as the limit.
    function automatic logic [DimW-1:0] screen_dim(input logic [CfgW-1:0] v);
        logic [DimW-1:0] r;
        if (v > CfgW'(MaxDim))
            r = DimW'(MaxDim);
        else
            r = DimW'(v);
        return r;
    endfunction

    // floor(t / 255) for t below 65280, without a divider.
    function automatic logic [7:0] div255(input logic [15:0] t);
        logic [16:0] s;
        s = {1'b0, t} + 17'(t[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

// ----- rtl/cab_front.sv -----
// ============================================================================
// cab_front: pixel placement and clipping
// Keeps the image column and row counters, places each accepted word on the
// screen, decides visibility and the end of the image, and hands the result
// on as one queue record.
// ============================================================================
module cab_front
    import cab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cab_cfg_t  cfg,
    input  logic      accept,
    input  logic [63:0] pixels,
    output cab_item_t item
);

    logic [PosW-1:0] column_reg, column_next;
    logic [PosW-1:0] row_reg, row_next;
    logic [PosW-1:0] column_eff, row_eff;
    logic [DimW-1:0] column_inc, row_inc;
    logic signed [CfgW:0] x_pos, y_pos;
    logic x_on, y_on;

    // A counter left beyond a shrunken image starts again at zero.
    assign column_eff = ({1'b0, column_reg} >= cfg.image_width) ? '0 : column_reg;
    assign row_eff    = ({1'b0, row_reg} >= cfg.image_height) ? '0 : row_reg;
    assign column_inc = {1'b0, column_eff} + DimW'(1);
    assign row_inc    = {1'b0, row_eff} + DimW'(1);

    // Screen position and clipping against the screen edges.
    assign x_pos = {cfg.pos_x[CfgW-1], cfg.pos_x} + $signed({2'b00, column_eff});
    assign y_pos = {cfg.pos_y[CfgW-1], cfg.pos_y} + $signed({2'b00, row_eff});
    assign x_on  = !x_pos[CfgW] && (x_pos[CfgW-1:0] < cfg.screen_width);
    assign y_on  = !y_pos[CfgW] && (y_pos[CfgW-1:0] < cfg.screen_height);

    // Record handed to the queue.
    always_comb
    begin
        item.visible = x_on && y_on;
        item.last    = (column_inc == cfg.image_width) && (row_inc == cfg.image_height);
        item.x       = x_pos[PosW-1:0];
        item.y       = y_pos[PosW-1:0];
        item.src     = pixels[31:0];
        item.dst     = pixels[63:32];
    end

    // Raster order advance of the counters.
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (accept)
        begin
            if (column_inc >= cfg.image_width)
            begin
                column_next = '0;
                row_next    = (row_inc >= cfg.image_height) ? '0 : row_inc[PosW-1:0];
            end
            else
            begin
                column_next = column_inc[PosW-1:0];
                row_next    = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

endmodule

// ----- rtl/cab_queue.sv -----
// ============================================================================
// cab_queue: short record queue between front and back end
// A small register queue that lets the input side keep taking words while
// the blend unit or the output is held.
// ============================================================================
module cab_queue
    import cab_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cab_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output cab_item_t pop_item
);

    cab_item_t        slots [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCntW-1:0] count_reg, count_next;

    assign full      = (count_reg == QCntW'(QueueDepth));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCntW'(push) - QCntW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage for the records themselves.
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCntW'(QueueDepth))
        else $error("queue fill count beyond depth");

    // Nothing is taken from an empty queue or added to a full one.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    // A lone push raises the count by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + QCntW'(1))
        else $error("queue count out of step with pushes");

endmodule

// ----- rtl/cab_back.sv -----
// ============================================================================
// cab_back: index and blend unit
// Two stages: the first forms the products of the row offset and of the
// blend, the second adds, divides by 255 and holds the finished word for
// the output side.
// ============================================================================
module cab_back
    import cab_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [DimW-1:0] screen_width,
    input  logic            item_valid,
    input  cab_item_t       item,
    output logic            item_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_visible,
    output logic            out_last,
    output logic [IdxW-1:0] out_index,
    output logic [31:0]     out_pixel
);

    localparam int unsigned RowProdW = PosW + DimW;

    logic                s1_valid_reg;
    logic                s1_visible_reg;
    logic                s1_last_reg;
    logic [PosW-1:0]     s1_x_reg;
    logic [RowProdW-1:0] s1_row_reg;
    logic [15:0]         s1_src_prod_reg [4];
    logic [15:0]         s1_dst_prod_reg [4];
    logic                s2_valid_reg;
    logic                s2_visible_reg;
    logic                s2_last_reg;
    logic [IdxW-1:0]     s2_index_reg;
    logic [31:0]         s2_pixel_reg;
    logic                s1_ready, s2_ready;
    logic [7:0]          alpha, alpha_inv;
    logic [7:0]          src_term [4];
    logic [IdxW-1:0]     index_sum;
    logic [31:0]         pixel_blend;

    // Stage handshake: a stage moves when the one after it has room.
    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign item_pop = item_valid && s1_ready;

    // Stage one operands; the alpha channel takes alpha times itself.
    assign alpha     = item.src[31:24];
    assign alpha_inv = 8'd255 - alpha;
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            src_term[c] = item.src[8*c +: 8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= item_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Stage one: row offset product and the two blend products per channel.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            s1_visible_reg <= item.visible;
            s1_last_reg    <= item.last;
            s1_x_reg       <= item.x;
            s1_row_reg     <= item.y * screen_width;
            for (int c = 0; c < 4; c++)
            begin
                s1_src_prod_reg[c] <= src_term[c] * alpha;
                s1_dst_prod_reg[c] <= item.dst[8*c +: 8] * alpha_inv;
            end
        end
    end

    // Stage two operands: index sum and the divided blend sums.
    assign index_sum = s1_row_reg[IdxW-1:0] + IdxW'(s1_x_reg);
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            pixel_blend[8*c +: 8] = div255(s1_src_prod_reg[c] + s1_dst_prod_reg[c]);
    end

    // Stage two: output register, zero fields for a clipped pixel.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_visible_reg <= s1_visible_reg;
            s2_last_reg    <= s1_last_reg;
            s2_index_reg   <= s1_visible_reg ? index_sum : '0;
            s2_pixel_reg   <= s1_visible_reg ? pixel_blend : '0;
        end
    end

    assign out_valid   = s2_valid_reg;
    assign out_visible = s2_visible_reg;
    assign out_last    = s2_last_reg;
    assign out_index   = s2_index_reg;
    assign out_pixel   = s2_pixel_reg;

    // A clipped pixel leaves with all data fields at zero.
    a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_visible) |-> (out_index == '0 && out_pixel == '0))
        else $error("clipped pixel carries data");

    // A word taken from the queue reaches stage one on the next edge.
    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> s1_valid_reg)
        else $error("popped record lost before stage one");

    // Stage one is never overwritten while it waits.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |=> (s1_valid_reg && $stable(s1_row_reg)))
        else $error("stage one changed while held");

endmodule

// ----- rtl/clipped_alpha_blend_blitter.sv -----
// ============================================================================
// clipped_alpha_blend_blitter: clipped source-over blitter, top level
// Holds the configuration registers, places each image pixel on the screen,
// clips it, and blends the source over the framebuffer pixel.
//
//  channel  | direction | word contents (lowest bits first)
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | src r,g,b,a, dst r,g,b,a (8 bits each)
//  m_axis   | out       | tdata: pixel_index, out r,g,b,a; tuser: visible; tlast
//  cfg      | in        | cfg_we, cfg_index, cfg_data (13 bits)
//
// One word per clock is taken and delivered when neither side holds.
// A word is written into the queue when it is taken, then passes the product
// stage register and the output register before it is offered on the output.
// The four-entry queue lets input go on during output stalls until it fills.
// Reset clears the counters, the queue and the pipeline and restores the
// register defaults. No clearing pass is needed.
// ============================================================================
module clipped_alpha_blend_blitter
    import cab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Pixel input.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,    // src_red, src_green, src_blue, src_alpha,
                                         // dst_red, dst_green, dst_blue, dst_alpha
    // Blended output.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [55:0]      m_tdata,    // pixel_index, out_red, out_green, out_blue,
                                         // out_alpha
    output logic [0:0]       m_tuser,    // visible
    output logic             m_tlast,
    // Configuration writes.
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CfgW-1:0]  cfg_data
);

    logic [CfgW-1:0] screen_width_reg, screen_height_reg;
    logic [CfgW-1:0] image_width_reg, image_height_reg;
    logic [CfgW-1:0] pos_x_reg, pos_y_reg;
    cab_cfg_t        cfg;
    cab_item_t       front_item, queue_item;
    logic            accept, queue_full, queue_not_empty, queue_pop;
    logic            out_visible;
    logic [IdxW-1:0] out_index;
    logic [31:0]     out_pixel;

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= CfgW'(640);
            screen_height_reg <= CfgW'(480);
            image_width_reg   <= CfgW'(1);
            image_height_reg  <= CfgW'(1);
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cab_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_POS_X:         pos_x_reg         <= cfg_data;
                REG_POS_Y:         pos_y_reg         <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective dimensions after clamping.
    always_comb
    begin
        cfg.screen_width  = screen_dim(screen_width_reg);
        cfg.screen_height = screen_dim(screen_height_reg);
        cfg.image_width   = image_dim(image_width_reg);
        cfg.image_height  = image_dim(image_height_reg);
        cfg.pos_x         = $signed(pos_x_reg);
        cfg.pos_y         = $signed(pos_y_reg);
    end

    // Input handshake: a word is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    cab_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .pixels (s_tdata),
        .item   (front_item)
    );

    cab_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_item  (queue_item)
    );

    cab_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .screen_width (cfg.screen_width),
        .item_valid   (queue_not_empty),
        .item         (queue_item),
        .item_pop     (queue_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_visible  (out_visible),
        .out_last     (m_tlast),
        .out_index    (out_index),
        .out_pixel    (out_pixel)
    );

    // Output word packing.
    assign m_tdata = {out_pixel, out_index};
    assign m_tuser = out_visible;

endmodule

// ----- tb/sv/clipped_alpha_blend_blitter_checker.sv -----
// ============================================================================
// clipped_alpha_blend_blitter_checker: prediction and comparison of blits
// Watches the pixel input, the register writes and the blended output of the
// blitter. It keeps its own copy of the registers and of the image column and
// row, works out the placed, clipped and blended word for every pixel taken,
// and compares each output word field by field with the oldest prediction.
// ============================================================================
module clipped_alpha_blend_blitter_checker
    import cab_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [55:0]      m_tdata,
    input  logic [0:0]       m_tuser,
    input  logic             m_tlast,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CfgW-1:0]  cfg_data,
    input  logic             end_of_run,
    output int               failures,
    output int               pending,
    output int               checked,
    output int               shown
);

    // Beyond this many mismatches the lines are no longer printed, only counted.
    localparam int ReportLimit = 40;

    typedef struct {
        logic        visible;
        logic [23:0] index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        tail;
    } blit_word_t;

    // Register copies and the position within the image.
    logic [CfgW-1:0] scr_w;
    logic [CfgW-1:0] scr_h;
    logic [CfgW-1:0] img_w;
    logic [CfgW-1:0] img_h;
    logic [CfgW-1:0] org_x;
    logic [CfgW-1:0] org_y;
    int              column;
    int              row;
    blit_word_t      blended_q[$];

    initial
    begin
        failures = 0;
        pending  = 0;
        checked  = 0;
        shown    = 0;
    end

    // Source-over of one channel with a floor division by 255.
    function automatic logic [7:0] over(input int s, input int d, input int a);
        return 8'((s * a + d * (255 - a)) / 255);
    endfunction

    // Effective dimension: large values saturate, and for the image zero means one.
    function automatic int limit_dim(input logic [CfgW-1:0] v, input bit zero_is_one);
        int r;
        r = int'(v);
        if (r > int'(MaxDim))
            r = int'(MaxDim);
        if (zero_is_one && r == 0)
            r = 1;
        return r;
    endfunction

    task automatic report(input string what);
        failures++;
        if (failures <= ReportLimit)
            $display("mismatch: %s", what);
    endtask

    // Model of the blitter, advanced on each accepted word.
    always @(posedge clk or negedge rst_n)
    begin : track
        int         iw;
        int         ih;
        int         sw;
        int         sh;
        int         x;
        int         y;
        int         a;
        blit_word_t w;
        blit_word_t e;
        if (!rst_n)
        begin
            scr_w  = 13'd640;
            scr_h  = 13'd480;
            img_w  = 13'd1;
            img_h  = 13'd1;
            org_x  = '0;
            org_y  = '0;
            column = 0;
            row    = 0;
            blended_q.delete();
            pending = 0;
        end
        else
        begin
            // Blended words leaving the block.
            if (m_tvalid && m_tready)
            begin
                checked++;
                if (m_tuser[0] === 1'b1)
                    shown++;
                if (blended_q.size() == 0)
                    report($sformatf("word %0d arrived with nothing expected: %h",
                                     checked, m_tdata));
                else
                begin
                    e = blended_q.pop_front();
                    if (m_tuser[0] !== e.visible)
                        report($sformatf("word %0d visible %b, expected %b",
                                         checked, m_tuser[0], e.visible));
                    if (m_tdata[23:0] !== e.index)
                        report($sformatf("word %0d pixel index %0d, expected %0d",
                                         checked, m_tdata[23:0], e.index));
                    if (m_tdata[31:24] !== e.red)
                        report($sformatf("word %0d red %0d, expected %0d",
                                         checked, m_tdata[31:24], e.red));
                    if (m_tdata[39:32] !== e.green)
                        report($sformatf("word %0d green %0d, expected %0d",
                                         checked, m_tdata[39:32], e.green));
                    if (m_tdata[47:40] !== e.blue)
                        report($sformatf("word %0d blue %0d, expected %0d",
                                         checked, m_tdata[47:40], e.blue));
                    if (m_tdata[55:48] !== e.alpha)
                        report($sformatf("word %0d alpha %0d, expected %0d",
                                         checked, m_tdata[55:48], e.alpha));
                    if (m_tlast !== e.tail)
                        report($sformatf("word %0d last %b, expected %b",
                                         checked, m_tlast, e.tail));
                end
            end

            // Pixels taken: place, clip and blend with the registers as they stand.
            if (s_tvalid && s_tready)
            begin
                iw = limit_dim(img_w, 1'b1);
                ih = limit_dim(img_h, 1'b1);
                sw = limit_dim(scr_w, 1'b0);
                sh = limit_dim(scr_h, 1'b0);
                // A smaller image set since the last pixel sends the counters home.
                if (column >= iw)
                    column = 0;
                if (row >= ih)
                    row = 0;
                x = int'($signed(org_x)) + column;
                y = int'($signed(org_y)) + row;
                a = int'(s_tdata[31:24]);
                w.visible = (x >= 0 && y >= 0 && x < sw && y < sh);
                w.tail    = (column == iw - 1 && row == ih - 1);
                if (w.visible)
                begin
                    w.index = 24'(y * sw + x);
                    w.red   = over(int'(s_tdata[7:0]),   int'(s_tdata[39:32]), a);
                    w.green = over(int'(s_tdata[15:8]),  int'(s_tdata[47:40]), a);
                    w.blue  = over(int'(s_tdata[23:16]), int'(s_tdata[55:48]), a);
                    w.alpha = over(a, int'(s_tdata[63:56]), a);
                end
                else
                begin
                    w.index = '0;
                    w.red   = '0;
                    w.green = '0;
                    w.blue  = '0;
                    w.alpha = '0;
                end
                blended_q.push_back(w);
                if (column + 1 >= iw)
                begin
                    column = 0;
                    row = (row + 1 >= ih) ? 0 : row + 1;
                end
                else
                    column++;
            end

            // Register writes apply from the following pixel on.
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w = cfg_data;
                    REG_SCREEN_HEIGHT: scr_h = cfg_data;
                    REG_IMAGE_WIDTH:   img_w = cfg_data;
                    REG_IMAGE_HEIGHT:  img_h = cfg_data;
                    REG_POS_X:         org_x = cfg_data;
                    REG_POS_Y:         org_y = cfg_data;
                    default:           ;
                endcase
            end
            pending = blended_q.size();
        end
    end

    // Any prediction still waiting at the end never got its word.
    always @(posedge end_of_run)
    begin
        foreach (blended_q[i])
            report($sformatf("expected word with index %0d never arrived",
                             blended_q[i].index));
    end

endmodule

// ----- tb/sv/clipped_alpha_blend_blitter_test.sv -----
// ============================================================================
// clipped_alpha_blend_blitter_test: stimulus and verdict for the blitter
// Drives pixel words and register writes into the blitter, with random gaps on
// the input and random stalls on the output. A directed opening covers the
// reset settings, clipping on every edge, an empty screen, saturated sizes and
// a size change part way through an image; random register settings follow,
// mostly small images against small screens so that clipping is frequent.
// ============================================================================
module clipped_alpha_blend_blitter_test;
    import cab_pkg::*;

    localparam int RandomItems = 1900;
    localparam int CycleLimit  = 400000;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [2:0] RegSpareLow  = 3'd6;
    localparam logic [2:0] RegSpareHigh = 3'd7;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [63:0]     s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [55:0]     m_tdata;
    logic [0:0]      m_tuser;
    logic            m_tlast;
    logic            cfg_we;
    logic [2:0]      cfg_index;
    logic [CfgW-1:0] cfg_data;
    logic            end_of_run;

    int failures;
    int pending;
    int checked;
    int shown;
    int src_idle;
    int sink_idle;
    int items_sent;
    int settings;
    int cycles;

    clipped_alpha_blend_blitter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    clipped_alpha_blend_blitter_checker blit_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .end_of_run (end_of_run),
        .failures   (failures),
        .pending    (pending),
        .checked    (checked),
        .shown      (shown)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Output stalls, drawn afresh on every falling edge.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // Watchdog on the whole run.
    initial
    begin
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("run stopped after %0d cycles", cycles);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] pixel_word(input logic [7:0] sr, input logic [7:0] sg,
                                               input logic [7:0] sb, input logic [7:0] sa,
                                               input logic [7:0] dr, input logic [7:0] dg,
                                               input logic [7:0] db, input logic [7:0] da);
        return {da, db, dg, dr, sa, sb, sg, sr};
    endfunction

    // Random pixel pair, with fully transparent and opaque sources made common.
    function automatic logic [63:0] random_pixel();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(7))
            0:       w[31:24] = 8'h00;
            1:       w[31:24] = 8'hFF;
            default: ;
        endcase
        return w;
    endfunction

    // Size at or past the edges of its range.
    function automatic logic [CfgW-1:0] edge_dim();
        logic [CfgW-1:0] v;
        case ($urandom_range(5))
            0:       v = '0;
            1:       v = 13'd1;
            2:       v = CfgW'(MaxDim);
            3:       v = '1;
            4:       v = CfgW'($urandom_range(MaxDim + 1, 8191));
            default: v = CfgW'($urandom_range(1, MaxDim));
        endcase
        return v;
    endfunction

    // Origin at the ends of its range or near the screen edges.
    function automatic logic [CfgW-1:0] edge_pos(input logic [CfgW-1:0] span);
        logic [CfgW-1:0] v;
        case ($urandom_range(4))
            0:       v = 13'h1000;
            1:       v = 13'h0FFF;
            2:       v = CfgW'($urandom);
            3:       v = span - 13'd2;
            default: v = CfgW'(-2);
        endcase
        return v;
    endfunction

    // Offer one word, with random gaps before it, and wait until it is taken.
    task automatic send_word(input logic [63:0] w);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every word in flight has come out.
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
    endtask

    // New register setting, written only once the block has gone quiet.
    task automatic set_geometry(input logic [CfgW-1:0] sw, input logic [CfgW-1:0] sh,
                                input logic [CfgW-1:0] iw, input logic [CfgW-1:0] ih,
                                input logic [CfgW-1:0] px, input logic [CfgW-1:0] py,
                                input bit spare);
        drain();
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
        write_reg(REG_IMAGE_WIDTH, iw);
        write_reg(REG_IMAGE_HEIGHT, ih);
        write_reg(REG_POS_X, px);
        write_reg(REG_POS_Y, py);
        if (spare)
            write_reg($urandom_range(1) ? RegSpareHigh : RegSpareLow, CfgW'($urandom));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin : stimulus
        int              random_items;
        int              n;
        logic [CfgW-1:0] sw;
        logic [CfgW-1:0] sh;
        logic [CfgW-1:0] iw;
        logic [CfgW-1:0] ih;
        logic [CfgW-1:0] px;
        logic [CfgW-1:0] py;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        end_of_run = 1'b0;
        src_idle   = 13;
        sink_idle  = 56;
        items_sent = 0;
        settings   = 0;
        random_items = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: each pixel is a one-pixel image at the screen origin.
        send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(pixel_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_word(pixel_word(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(pixel_word(8'hAA, 8'h55, 8'h0F, 8'h80, 8'h55, 8'hAA, 8'hF0, 8'h7F));

        // Image hanging off the top left corner, with stray writes past the list.
        set_geometry(13'd4, 13'd3, 13'd3, 13'd2, CfgW'(-1), CfgW'(-1), 1'b1);
        repeat (6) send_word(random_pixel());

        // Image hanging off the bottom right corner.
        set_geometry(13'd2, 13'd2, 13'd2, 13'd2, 13'd1, 13'd1, 1'b0);
        repeat (4) send_word(random_pixel());

        // Screen of zero width: nothing is visible.
        set_geometry(13'd0, 13'd5, 13'd2, 13'd1, 13'd0, 13'd0, 1'b0);
        repeat (2) send_word(random_pixel());

        // Saturated sizes, zero image height, and the far screen corner.
        set_geometry('1, '1, '1, 13'd0, 13'd4094, 13'd4095, 1'b0);
        repeat (3) send_word(random_pixel());

        // Narrower image while the column counter sits beyond it.
        set_geometry(13'd5000, 13'd1, 13'd2, 13'd1, CfgW'(-1), 13'd0, 1'b0);
        repeat (2) send_word(random_pixel());

        // Random settings under three idling regimes.
        while (random_items < RandomItems)
        begin
            if (random_items < RandomItems / 3)
            begin
                src_idle  = 13;
                sink_idle = 56;
            end
            else if (random_items < 2 * RandomItems / 3)
            begin
                src_idle  = 56;
                sink_idle = 13;
            end
            else
            begin
                src_idle  = 0;
                sink_idle = 0;
            end
            if ($urandom_range(7) == 0)
            begin
                sw = edge_dim();
                sh = edge_dim();
                iw = edge_dim();
                ih = edge_dim();
                px = edge_pos(sw);
                py = edge_pos(sh);
                n  = $urandom_range(1, 40);
            end
            else
            begin
                sw = CfgW'($urandom_range(1, 12));
                sh = CfgW'($urandom_range(1, 10));
                iw = CfgW'($urandom_range(0, 7));
                ih = CfgW'($urandom_range(0, 5));
                px = CfgW'($urandom_range(0, 20) - 8);
                py = CfgW'($urandom_range(0, 16) - 6);
                // Mostly whole images, now and then stopping part way through one.
                n  = $urandom_range(1, 3) * ((iw == 0) ? 1 : int'(iw))
                     * ((ih == 0) ? 1 : int'(ih)) + $urandom_range(0, 3);
            end
            set_geometry(sw, sh, iw, ih, px, py, ($urandom_range(9) == 0));
            repeat (n)
            begin
                if (random_items == RandomItems / 2)
                    drain();
                send_word(random_pixel());
                random_items++;
            end
        end

        // Let the last words out, then wait for stragglers before ending the run.
        drain();
        repeat (8) @(negedge clk);
        end_of_run <= 1'b1;
        @(negedge clk);

        $display("Blitted %0d pixels under %0d register settings past the reset values;",
                 items_sent, settings);
        $display("%0d output words compared, %0d of them on screen.", checked, shown);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
